@@ rtl/core/bcdtod_pkg.sv @@
`timescale 1ns / 1ps

package bcdtod_pkg;

    // Operation codes carried in the operation field of an input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register indexes of the time and alarm bytes.
    localparam logic [1:0] REG_TENTHS  = 2'd0;
    localparam logic [1:0] REG_SECONDS = 2'd1;
    localparam logic [1:0] REG_MINUTES = 2'd2;
    localparam logic [1:0] REG_HOURS   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_FIFTY_HZ     = 1'b0;
    localparam logic CFG_ALARM_SELECT = 1'b1;

    // Write masks and the special hour value.
    localparam logic [7:0] MASK_TENTHS = 8'h0f;
    localparam logic [7:0] MASK_MINSEC = 8'h7f;
    localparam logic [7:0] MASK_HOURS  = 8'h9f;
    localparam logic [4:0] HOUR_TWELVE = 5'h12;
    localparam logic [7:0] PM_BIT      = 8'h80;

    // Reset value of the time: 1 o'clock AM, everything else zero.
    localparam logic [3:0][7:0] TIME_RESET = {8'h01, 8'h00, 8'h00, 8'h00};

    typedef logic [3:0][7:0] tod_bytes_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] register_index;
        logic [7:0] write_data;
    } bcdtod_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       alarm_match;
    } bcdtod_out_t;

    typedef struct packed {
        logic       clock_stopped;
        logic [2:0] line_divider;
    } bcdtod_status_t;

endpackage

@@ rtl/core/bcd_time_of_day_clock_core.sv @@
`timescale 1ns / 1ps

// BCD time-of-day clock with tenths, seconds, minutes and 12-hour hours with
// an AM/PM flag in bit 7 of the hours byte. Each input beat is a power-line
// tick, a register read or a register write; each produces exactly one result
// beat carrying the read byte (zero for anything but a read) and an alarm
// match flag. A beat is captured in an input register, processed by the clock
// state when the output register can take it, and written to that output
// register; one beat is taken every cycle for as long as the output side
// keeps up, and the update of the clock state from the beat held in the
// input register sets that rate. The output register lets a new beat enter
// while a finished result still waits. After reset the clock is stopped at
// 1:00:00.0 AM and starts counting once the tenths byte is written. The
// configuration port selects 50 Hz or 60 Hz line ticks and whether writes go
// to the alarm or to the time; write it only while no beat is in flight.
module bcd_time_of_day_clock_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic                    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  bcdtod_pkg::bcdtod_in_t  in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output bcdtod_pkg::bcdtod_out_t out_data
);
    import bcdtod_pkg::*;

    logic           in_vld_reg;
    bcdtod_in_t     in_item_reg;
    logic           out_vld_reg;
    bcdtod_out_t    out_item_reg;
    logic           stage_fire;
    bcdtod_out_t    result;
    bcdtod_status_t status;

    // The captured beat moves on whenever the output register is empty or
    // its content is being taken in this cycle.
    assign stage_fire = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall   = in_vld_reg && !stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    bcdtod_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_fire (stage_fire),
        .item      (in_item_reg),
        .result    (result),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || !out_stall)
        begin
            out_vld_reg <= stage_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTHESIS
    // The ring divider only ever visits its six sequence states.
    a_divider_ring: assert property (@(posedge clk) disable iff (!rst_n)
        status.line_divider != 3'd2 && status.line_divider != 3'd5)
        else $error("line divider left its ring sequence");

    // While stopped, the divider holds or is cleared by a restart.
    a_stopped_divider: assert property (@(posedge clk) disable iff (!rst_n)
        status.clock_stopped |=>
            (status.line_divider == $past(status.line_divider)
             || status.line_divider == 3'd0))
        else $error("line divider moved while the clock was stopped");

    // A read never reports a match and a non-read never returns data.
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_item_reg.alarm_match && out_item_reg.read_data != 8'd0))
        else $error("result carries both read data and an alarm match");

    // Backpressure on the input only arises from a held beat.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked beat behind it");
`endif

endmodule

@@ rtl/core/bcdtod_advance.sv @@
`timescale 1ns / 1ps

module bcdtod_advance (
    input  bcdtod_pkg::tod_bytes_t time_bytes,
    output bcdtod_pkg::tod_bytes_t time_advanced
);
    import bcdtod_pkg::*;

    logic [3:0] ts;
    logic [3:0] sl;
    logic [2:0] sh;
    logic [3:0] ml;
    logic [2:0] mh;
    logic [3:0] hl;
    logic       hh;
    logic       pm;

    // Each digit counts within its own width and only carries on reaching
    // its limit, so out-of-range digits wrap without a carry.
    always_comb
    begin
        ts = time_bytes[0][3:0] + 4'd1;
        sl = time_bytes[1][3:0];
        sh = time_bytes[1][6:4];
        ml = time_bytes[2][3:0];
        mh = time_bytes[2][6:4];
        hl = time_bytes[3][3:0];
        hh = time_bytes[3][4];
        pm = time_bytes[3][7];
        if (ts == 4'd10)
        begin
            ts = 4'd0;
            sl = sl + 4'd1;
            if (sl == 4'd10)
            begin
                sl = 4'd0;
                sh = sh + 3'd1;
                if (sh == 3'd6)
                begin
                    sh = 3'd0;
                    ml = ml + 4'd1;
                    if (ml == 4'd10)
                    begin
                        ml = 4'd0;
                        mh = mh + 3'd1;
                        if (mh == 3'd6)
                        begin
                            mh = 3'd0;
                            if ((hl == 4'd2 && hh) || (hl == 4'd9 && !hh))
                            begin
                                // 12 rolls to 1 and 9 rolls to 10.
                                hl = {3'd0, hh};
                                hh = !hh;
                            end
                            else
                            begin
                                hl = hl + 4'd1;
                                if (hl == 4'd2 && hh)
                                begin
                                    pm = !pm;
                                end
                            end
                        end
                    end
                end
            end
        end
        time_advanced[0] = {4'd0, ts};
        time_advanced[1] = {1'b0, sh, sl};
        time_advanced[2] = {1'b0, mh, ml};
        time_advanced[3] = {pm, 2'd0, hh, hl};
    end

endmodule

@@ rtl/core/bcdtod_state.sv @@
`timescale 1ns / 1ps

module bcdtod_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic                   cfg_data,
    input  logic                   item_fire,
    input  bcdtod_pkg::bcdtod_in_t item,
    output bcdtod_pkg::bcdtod_out_t result,
    output bcdtod_pkg::bcdtod_status_t status
);
    import bcdtod_pkg::*;

    tod_bytes_t time_reg;
    tod_bytes_t time_next;
    tod_bytes_t latch_reg;
    tod_bytes_t latch_next;
    tod_bytes_t alarm_reg;
    tod_bytes_t alarm_next;
    logic       held_reg;
    logic       held_next;
    logic       stopped_reg;
    logic       stopped_next;
    logic [2:0] divider_reg;
    logic [2:0] divider_next;
    logic       fifty_reg;
    logic       alarm_sel_reg;

    tod_bytes_t time_advanced;
    tod_bytes_t latch_source;
    logic [7:0] wr_byte;
    logic       changed;

    bcdtod_advance u_advance (
        .time_bytes    (time_reg),
        .time_advanced (time_advanced)
    );

    always_comb
    begin
        time_next          = time_reg;
        latch_next         = latch_reg;
        alarm_next         = alarm_reg;
        held_next          = held_reg;
        stopped_next       = stopped_reg;
        divider_next       = divider_reg;
        latch_source       = held_reg ? latch_reg : time_reg;
        wr_byte            = 8'd0;
        changed            = 1'b0;
        result.read_data   = 8'd0;
        result.alarm_match = 1'b0;
        case (item.operation)
            OP_TICK:
            begin
                if (!stopped_reg)
                begin
                    if (divider_reg == {1'b0, fifty_reg, 1'b1})
                    begin
                        divider_next       = 3'd0;
                        time_next          = time_advanced;
                        result.alarm_match = (alarm_reg == time_advanced);
                    end
                    else
                    begin
                        // Ring sequence 0, 4, 6, 7, 3, 1.
                        divider_next = {~divider_reg[0], divider_reg[2], divider_reg[1]};
                    end
                end
            end
            OP_READ:
            begin
                latch_next = latch_source;
                if (item.register_index == REG_TENTHS)
                begin
                    held_next = 1'b0;
                end
                else if (item.register_index == REG_HOURS)
                begin
                    held_next = 1'b1;
                end
                result.read_data = latch_source[item.register_index];
            end
            OP_WRITE:
            begin
                case (item.register_index)
                    REG_TENTHS:
                    begin
                        wr_byte = item.write_data & MASK_TENTHS;
                    end
                    REG_SECONDS, REG_MINUTES:
                    begin
                        wr_byte = item.write_data & MASK_MINSEC;
                    end
                    default:
                    begin
                        wr_byte = item.write_data & MASK_HOURS;
                        if (wr_byte[4:0] == HOUR_TWELVE && !alarm_sel_reg)
                        begin
                            wr_byte = wr_byte ^ PM_BIT;
                        end
                    end
                endcase
                if (alarm_sel_reg)
                begin
                    changed = (alarm_reg[item.register_index] != wr_byte);
                    alarm_next[item.register_index] = wr_byte;
                end
                else
                begin
                    if (item.register_index == REG_TENTHS && stopped_reg)
                    begin
                        divider_next = 3'd0;
                        stopped_next = 1'b0;
                    end
                    else if (item.register_index == REG_HOURS)
                    begin
                        stopped_next = 1'b1;
                    end
                    changed = (time_reg[item.register_index] != wr_byte);
                    time_next[item.register_index] = wr_byte;
                end
                result.alarm_match = changed && (alarm_next == time_next);
            end
            default:
            begin
                result.read_data   = 8'd0;
                result.alarm_match = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= TIME_RESET;
            latch_reg   <= TIME_RESET;
            alarm_reg   <= '0;
            held_reg    <= 1'b0;
            stopped_reg <= 1'b1;
            divider_reg <= 3'd0;
        end
        else if (item_fire)
        begin
            time_reg    <= time_next;
            latch_reg   <= latch_next;
            alarm_reg   <= alarm_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
            divider_reg <= divider_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifty_reg     <= 1'b0;
            alarm_sel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FIFTY_HZ)
            begin
                fifty_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ALARM_SELECT)
            begin
                alarm_sel_reg <= cfg_data;
            end
        end
    end

    assign status.clock_stopped = stopped_reg;
    assign status.line_divider  = divider_reg;

endmodule
